>>> sv/mbps_pkg.sv
// Package for the multicolor bitmap pixel store.
// Holds access codes, mode codes, register indexes, reset values and the
// controller/datapath interface types. No dependencies.
package mbps_pkg;

    // Access codes carried on func
    typedef enum logic [1:0] {
        FUNC_RD_PIX  = 2'd0,
        FUNC_WR_PIX  = 2'd1,
        FUNC_RD_CELL = 2'd2,
        FUNC_WR_CELL = 2'd3
    } func_t;

    // Pixel mode codes (code three behaves as hires)
    localparam logic [1:0] MODE_HIRES = 2'd0;
    localparam logic [1:0] MODE_MULTI = 2'd1;
    localparam logic [1:0] MODE_CMAP  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PIXEL_MODE    = 2'd0;
    localparam logic [1:0] CFG_BITMAP_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_BITMAP_HEIGHT = 2'd2;

    // Register widths and reset values
    localparam int CFG_DATA_W = 10;
    localparam logic [1:0] RST_PIXEL_MODE    = MODE_HIRES;
    localparam logic [9:0] RST_BITMAP_WIDTH  = 10'd320;
    localparam logic [8:0] RST_BITMAP_HEIGHT = 9'd192;

    // Store word widths: one pixel word holds eight pixels of a row
    localparam int PIX_WORD_W = 8;
    localparam int CELL_W     = 8;

    // Cell value above which a pixel is multicolor in color-map mode
    localparam logic [7:0] CELL_MC_LIMIT = 8'd7;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_en;
        logic load;
        logic rd_en;
        logic exec;
    } mbps_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
    } mbps_stat_t;

endpackage

>>> sv/mbps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/mbps_ctrl.sv
// Controller of the pixel store: clearing pass, accept, read, execute.
// Depends on mbps_pkg.
module mbps_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mbps_pkg::mbps_stat_t stat,
    output mbps_pkg::mbps_cmd_t  cmd,
    output logic               busy
);
    import mbps_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
            end
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/mbps_dpath.sv
// Datapath of the pixel store: config registers, item registers, the pixel
// and cell memories, range checks and read-modify-write of pixel words.
// Depends on mbps_pkg and mbps_ram.
module mbps_dpath #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mbps_pkg::mbps_cmd_t             cmd,
    output mbps_pkg::mbps_stat_t            stat,
    input  logic                            cfg_wr,
    input  logic [1:0]                      cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [1:0]                      func,
    input  logic [9:0]                      xpos,
    input  logic [8:0]                      ypos,
    input  logic [7:0]                      wvalue,
    output logic [7:0]                      rvalue,
    output logic                            done
);
    import mbps_pkg::*;

    // Store geometry
    localparam int ROW_WORDS  = (MAX_WIDTH + 7) / 8;
    localparam int CELL_COLS  = ROW_WORDS;
    localparam int CELL_ROWS  = (MAX_HEIGHT + 7) / 8;
    localparam int PIX_DEPTH  = ROW_WORDS * MAX_HEIGHT;
    localparam int CELL_DEPTH = CELL_COLS * CELL_ROWS;
    localparam int PAW = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
    localparam int CAW = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
    localparam int CLR_LEN = (PIX_DEPTH > CELL_DEPTH) ? PIX_DEPTH : CELL_DEPTH;
    localparam int CW = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;

    // Linear address widths: 9-bit row times row words plus column
    localparam int RWW = $clog2(ROW_WORDS + 1);
    localparam int LMW = ((PAW > CAW) ? PAW : CAW);
    localparam int LW  = ((LMW > 9 + RWW) ? LMW : 9 + RWW) + 1;

    // Compare width for coordinates against sizes in use
    localparam int WUW = ($clog2(MAX_WIDTH + 1) > 10) ? $clog2(MAX_WIDTH + 1) : 10;
    localparam int HUW = ($clog2(MAX_HEIGHT + 1) > 9) ? $clog2(MAX_HEIGHT + 1) : 9;
    localparam int KW  = ((WUW > HUW) ? WUW : HUW) + 1;

    // Configuration registers
    logic [1:0] mode_reg;
    logic [9:0] width_reg;
    logic [8:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= RST_PIXEL_MODE;
            width_reg  <= RST_BITMAP_WIDTH;
            height_reg <= RST_BITMAP_HEIGHT;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_PIXEL_MODE:    mode_reg   <= cfg_data[1:0];
                CFG_BITMAP_WIDTH:  width_reg  <= cfg_data[9:0];
                CFG_BITMAP_HEIGHT: height_reg <= cfg_data[8:0];
                default:           ;
            endcase
        end
    end

    // Clearing pass counter
    logic [CW-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign stat.clr_last = (clr_cnt_reg == CW'(CLR_LEN - 1));

    // Item registers, loaded on transfer
    func_t      func_reg;
    logic [9:0] x_reg;
    logic [8:0] y_reg;
    logic [7:0] v_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func_t'(func);
            x_reg    <= xpos;
            y_reg    <= ypos;
            v_reg    <= wvalue;
        end
    end

    // Sizes in use, saturated at the store maximum
    logic [KW-1:0] wuse;
    logic [KW-1:0] huse;
    logic [KW-1:0] ccols_use;
    logic [KW-1:0] crows_use;

    always_comb
    begin
        wuse = (KW'(width_reg) > KW'(MAX_WIDTH)) ? KW'(MAX_WIDTH) : KW'(width_reg);
        huse = (KW'(height_reg) > KW'(MAX_HEIGHT)) ? KW'(MAX_HEIGHT) : KW'(height_reg);
        ccols_use = (wuse + KW'(7)) >> 3;
        crows_use = (huse + KW'(7)) >> 3;
    end

    // Pixel range checks: the addressed bit and each bit of the pair
    logic [9:0] xe;
    logic [9:0] xo;
    logic       y_in;
    logic       x_in;
    logic       e_in;
    logic       o_in;

    always_comb
    begin
        xe   = {x_reg[9:1], 1'b0};
        xo   = {x_reg[9:1], 1'b1};
        y_in = KW'(y_reg) < huse;
        x_in = y_in && (KW'(x_reg) < wuse);
        e_in = y_in && (KW'(xe) < wuse);
        o_in = y_in && (KW'(xo) < wuse);
    end

    // Cell coordinates: covering cell for pixel accesses, direct otherwise
    logic          cell_op;
    logic [9:0]    cx;
    logic [8:0]    cy;
    logic          cell_in;
    logic [LW-1:0] cell_lin;
    logic [LW-1:0] pix_lin;

    always_comb
    begin
        cell_op = (func_reg == FUNC_RD_CELL) || (func_reg == FUNC_WR_CELL);
        if (cell_op)
        begin
            cx = x_reg;
            cy = y_reg;
        end
        else
        begin
            cx = {3'b000, x_reg[9:3]};
            cy = {3'b000, y_reg[8:3]};
        end
        cell_in  = (KW'(cx) < ccols_use) && (KW'(cy) < crows_use);
        cell_lin = LW'(cy) * LW'(CELL_COLS) + LW'(cx);
        pix_lin  = LW'(y_reg) * LW'(ROW_WORDS) + LW'(x_reg[9:3]);
    end

    // Memories
    logic                  pix_we;
    logic [PAW-1:0]        pix_waddr;
    logic [PIX_WORD_W-1:0] pix_wdata;
    logic [PIX_WORD_W-1:0] pix_rdata;
    logic                  cell_we;
    logic [CAW-1:0]        cell_waddr;
    logic [CELL_W-1:0]     cell_wdata;
    logic [CELL_W-1:0]     cell_rdata;

    mbps_ram #(
        .WIDTH (PIX_WORD_W),
        .DEPTH (PIX_DEPTH),
        .AW    (PAW)
    ) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (pix_wdata),
        .re    (cmd.rd_en),
        .raddr (pix_lin[PAW-1:0]),
        .rdata (pix_rdata)
    );

    mbps_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_DEPTH),
        .AW    (CAW)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .re    (cmd.rd_en),
        .raddr (cell_lin[CAW-1:0]),
        .rdata (cell_rdata)
    );

    // Execute: multicolor decision, rectification, word update, result
    logic [7:0]            cell_val;
    logic                  multi;
    logic [7:0]            v_rect;
    logic [2:0]            be;
    logic [2:0]            bo;
    logic [2:0]            bx;
    logic [PIX_WORD_W-1:0] word_upd;
    logic                  pix_upd;
    logic [7:0]            result;

    always_comb
    begin
        cell_val = cell_in ? cell_rdata : 8'd0;
        multi    = (mode_reg == MODE_MULTI) ||
                   ((mode_reg == MODE_CMAP) && (cell_val > CELL_MC_LIMIT));
        be = {x_reg[2:1], 1'b0};
        bo = {x_reg[2:1], 1'b1};
        bx = x_reg[2:0];

        v_rect = v_reg;
        if (multi && (mode_reg == MODE_CMAP) && v_reg[0])
        begin
            v_rect[1] = ~v_reg[1];
        end

        word_upd = pix_rdata;
        pix_upd  = 1'b0;
        result   = v_rect;
        case (func_reg)
            FUNC_RD_PIX:
            begin
                if (multi)
                begin
                    result = {6'd0, e_in & pix_rdata[be], o_in & pix_rdata[bo]};
                end
                else
                begin
                    result = {7'd0, x_in & pix_rdata[bx]};
                end
            end
            FUNC_WR_PIX:
            begin
                if (multi)
                begin
                    if (e_in)
                    begin
                        word_upd[be] = v_rect[1];
                    end
                    if (o_in)
                    begin
                        word_upd[bo] = v_rect[0];
                    end
                    pix_upd = e_in || o_in;
                end
                else
                begin
                    word_upd[bx] = v_reg[0];
                    pix_upd      = x_in;
                end
            end
            FUNC_RD_CELL:
            begin
                result = cell_val;
            end
            default:
            begin
                result = v_reg;
            end
        endcase
    end

    // Write ports: zero sweep during clear, item writes in execute
    always_comb
    begin
        if (cmd.clr_en)
        begin
            pix_we     = (clr_cnt_reg < CW'(PIX_DEPTH - 1)) ||
                         (clr_cnt_reg == CW'(PIX_DEPTH - 1));
            pix_waddr  = PAW'(clr_cnt_reg);
            pix_wdata  = '0;
            cell_we    = (clr_cnt_reg < CW'(CELL_DEPTH - 1)) ||
                         (clr_cnt_reg == CW'(CELL_DEPTH - 1));
            cell_waddr = CAW'(clr_cnt_reg);
            cell_wdata = '0;
        end
        else
        begin
            pix_we     = cmd.exec && (func_reg == FUNC_WR_PIX) && pix_upd;
            pix_waddr  = pix_lin[PAW-1:0];
            pix_wdata  = word_upd;
            cell_we    = cmd.exec && (func_reg == FUNC_WR_CELL) && cell_in;
            cell_waddr = cell_lin[CAW-1:0];
            cell_wdata = v_reg;
        end
    end

    // Result register and strobe
    logic [7:0] rvalue_reg;
    logic       done_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rvalue_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.exec;
        end
    end

    assign rvalue = rvalue_reg;
    assign done   = done_reg;

endmodule

>>> sv/multicolor_bitmap_pixel_store.sv
// A start transfer in idle loads the item; the read state reads both stores, the execute
// state updates the pixel word and registers the result and the done strobe. Busy stays
// high through read and execute, so a new item waits until the last is done. Reset:
// config returns to mode hires, 320 x 192; a clearing pass over the larger store depth
// (16384 at defaults) zeroes both stores with busy high. Results cannot be stalled.
// Depends on mbps_pkg, mbps_ctrl, mbps_dpath, mbps_ram.
module multicolor_bitmap_pixel_store #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      func,
    input  logic [9:0]                      xpos,
    input  logic [8:0]                      ypos,
    input  logic [7:0]                      wvalue,
    output logic                            done,
    output logic [7:0]                      rvalue,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mbps_pkg::*;

    mbps_cmd_t  cmd;
    mbps_stat_t stat;

    // Config writes are taken in every cycle
    assign cfg_ready = 1'b1;

    mbps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    mbps_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .func      (func),
        .xpos      (xpos),
        .ypos      (ypos),
        .wvalue    (wvalue),
        .rvalue    (rvalue),
        .done      (done)
    );

`ifndef SYNTH
    // Every accepted transfer is followed by its result strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result strobe missing three cycles after transfer");

    // The strobe lands when the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // A strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // An accepted item keeps the block busy through its work
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy ##1 busy)
        else $error("block free while an item is in flight");
`endif

endmodule

>>> dv/tb_multicolor_bitmap_pixel_store.sv
// Self-checking testbench for multicolor_bitmap_pixel_store: directed table, then random
// access phases under several size and mode settings, checked against a predictor model.
// Depends on mbps_pkg and the multicolor_bitmap_pixel_store RTL.
module tb_multicolor_bitmap_pixel_store;
    timeunit 1ns;
    timeprecision 1ps;

    import mbps_pkg::*;

    localparam int MAX_W      = 512;
    localparam int MAX_H      = 256;
    localparam int CELL_COLS  = (MAX_W + 7) / 8;
    localparam int CELL_ROWS  = (MAX_H + 7) / 8;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_LEN  = 130;
    localparam int DIR_N      = 36;

    // mode code three has no package name; it behaves as hires
    localparam logic [1:0] MODE_THREE = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] func;
    logic [9:0] xpos;
    logic [8:0] ypos;
    logic [7:0] wvalue;
    logic       done;
    logic [7:0] rvalue;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    multicolor_bitmap_pixel_store #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .xpos      (xpos),
        .ypos      (ypos),
        .wvalue    (wvalue),
        .done      (done),
        .rvalue    (rvalue),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Shadow of the block state and registers
    bit         pixel_mem [MAX_W*MAX_H];
    bit [7:0]   cell_mem  [CELL_COLS*CELL_ROWS];
    logic [1:0] cur_mode   = RST_PIXEL_MODE;
    logic [9:0] cur_width  = RST_BITMAP_WIDTH;
    logic [8:0] cur_height = RST_BITMAP_HEIGHT;

    logic [7:0] rvalue_due [$];
    logic [7:0] want;
    int         errors = 0;
    int         n_results = 0;
    int         n_reg_writes = 0;
    int         n_by_func [4] = '{0, 0, 0, 0};

    // Directed table row: one access, or one register write
    typedef struct packed {
        func_t      f;
        logic [9:0] x;
        logic [8:0] y;
        logic [7:0] v;
        logic       chk;
        logic [7:0] typed;
        logic       is_reg;
        logic [1:0] idx;
        logic [9:0] data;
    } dir_row_t;

    dir_row_t dir_rows [DIR_N] = '{
        // cleared stores, out-of-range reads
        '{FUNC_RD_PIX,  10'd0,    9'd0,   8'd0,   1'b1, 8'd0,   1'b0, CFG_PIXEL_MODE, 10'd0},
        '{FUNC_RD_CELL, 10'd0,    9'd0,   8'd0,   1'b1, 8'd0,   1'b0, CFG_PIXEL_MODE, 10'd0},
        '{FUNC_RD_CELL, 10'd1023, 9'd511, 8'd0,   1'b1, 8'd0,   1'b0, CFG_PIXEL_MODE, 10'd0},
        // hires writes at the corners of the default size
        '{FUNC_WR_PIX,  10'd0,    9'd0,   8'hFF,  1'b1, 8'hFF,  1'b0, CFG_PIXEL_MODE, 10'd0},
        '{FUNC_RD_PIX,  10'd0,    9'd0,   8'd0,   1'b1, 8'd1,   1'b0, CFG_PIXEL_MODE, 10'd0},
        '{FUNC_WR_PIX,  10'd319,  9'd191, 8'd1,   1'b1, 8'd1,   1'b0, CFG_PIXEL_MODE, 10'd0},
        '{FUNC_WR_PIX,  10'd320,  9'd0,   8'd1,   1'b1, 8'd1,   1'b0, CFG_PIXEL_MODE, 10'd0},
        '{FUNC_RD_PIX,  10'd320,  9'd0,   8'd0,   1'b1, 8'd0,   1'b0, CFG_PIXEL_MODE, 10'd0},
        // cell store, last cell in range and first one past it
        '{FUNC_WR_CELL, 10'd39,   9'd23,  8'hFF,  1'b1, 8'hFF,  1'b0, CFG_PIXEL_MODE, 10'd0},
        '{FUNC_RD_CELL, 10'd39,   9'd23,  8'd0,   1'b1, 8'hFF,  1'b0, CFG_PIXEL_MODE, 10'd0},
        '{FUNC_WR_CELL, 10'd40,   9'd0,   8'hAA,  1'b1, 8'hAA,  1'b0, CFG_PIXEL_MODE, 10'd0},
        '{FUNC_RD_CELL, 10'd40,   9'd0,   8'd0,   1'b1, 8'd0,   1'b0, CFG_PIXEL_MODE, 10'd0},
        // cells on both sides of the multicolor threshold
        '{FUNC_WR_CELL, 10'd0,    9'd0,   8'd8,   1'b1, 8'd8,   1'b0, CFG_PIXEL_MODE, 10'd0},
        '{FUNC_WR_CELL, 10'd1,    9'd0,   8'd7,   1'b1, 8'd7,   1'b0, CFG_PIXEL_MODE, 10'd0},
        '{FUNC_WR_CELL, 10'd2,    9'd0,   8'd200, 1'b1, 8'd200, 1'b0, CFG_PIXEL_MODE, 10'd0},
        // color-map mode: rectified write, then hires cell
        '{FUNC_RD_PIX,  10'd0,    9'd0,   8'd0,   1'b0, 8'd0,   1'b1, CFG_PIXEL_MODE,
          10'(MODE_CMAP)},
        '{FUNC_WR_PIX,  10'd3,    9'd0,   8'd1,   1'b1, 8'd3,   1'b0, CFG_PIXEL_MODE, 10'd0},
        '{FUNC_RD_PIX,  10'd2,    9'd0,   8'd0,   1'b1, 8'd3,   1'b0, CFG_PIXEL_MODE, 10'd0},
        '{FUNC_WR_PIX,  10'd9,    9'd0,   8'd1,   1'b1, 8'd1,   1'b0, CFG_PIXEL_MODE, 10'd0},
        // multicolor mode
        '{FUNC_RD_PIX,  10'd0,    9'd0,   8'd0,   1'b0, 8'd0,   1'b1, CFG_PIXEL_MODE,
          10'(MODE_MULTI)},
        '{FUNC_WR_PIX,  10'd5,    9'd1,   8'd2,   1'b1, 8'd2,   1'b0, CFG_PIXEL_MODE, 10'd0},
        '{FUNC_RD_PIX,  10'd4,    9'd1,   8'd0,   1'b1, 8'd2,   1'b0, CFG_PIXEL_MODE, 10'd0},
        // pair straddling the right edge: each bit checked alone
        '{FUNC_RD_PIX,  10'd0,    9'd0,   8'd0,   1'b0, 8'd0,   1'b1, CFG_BITMAP_WIDTH, 10'd319},
        '{FUNC_WR_PIX,  10'd318,  9'd2,   8'd3,   1'b1, 8'd3,   1'b0, CFG_PIXEL_MODE, 10'd0},
        '{FUNC_RD_PIX,  10'd319,  9'd2,   8'd0,   1'b1, 8'd2,   1'b0, CFG_PIXEL_MODE, 10'd0},
        // mode code three reads as hires
        '{FUNC_RD_PIX,  10'd0,    9'd0,   8'd0,   1'b0, 8'd0,   1'b1, CFG_PIXEL_MODE,
          10'(MODE_THREE)},
        '{FUNC_RD_PIX,  10'd3,    9'd0,   8'd0,   1'b1, 8'd1,   1'b0, CFG_PIXEL_MODE, 10'd0},
        // size registers above the maximum saturate
        '{FUNC_RD_PIX,  10'd0,    9'd0,   8'd0,   1'b0, 8'd0,   1'b1, CFG_BITMAP_WIDTH, 10'd1023},
        '{FUNC_RD_PIX,  10'd0,    9'd0,   8'd0,   1'b0, 8'd0,   1'b1, CFG_BITMAP_HEIGHT, 10'd511},
        '{FUNC_WR_PIX,  10'd511,  9'd255, 8'd1,   1'b1, 8'd1,   1'b0, CFG_PIXEL_MODE, 10'd0},
        '{FUNC_RD_PIX,  10'd511,  9'd255, 8'd0,   1'b1, 8'd1,   1'b0, CFG_PIXEL_MODE, 10'd0},
        // covering cell out of range reads as zero, so the pixel is hires
        '{FUNC_RD_PIX,  10'd0,    9'd0,   8'd0,   1'b0, 8'd0,   1'b1, CFG_BITMAP_WIDTH, 10'd16},
        '{FUNC_RD_PIX,  10'd0,    9'd0,   8'd0,   1'b0, 8'd0,   1'b1, CFG_BITMAP_HEIGHT, 10'd8},
        '{FUNC_RD_PIX,  10'd0,    9'd0,   8'd0,   1'b0, 8'd0,   1'b1, CFG_PIXEL_MODE,
          10'(MODE_CMAP)},
        '{FUNC_WR_PIX,  10'd17,   9'd0,   8'd1,   1'b1, 8'd1,   1'b0, CFG_PIXEL_MODE, 10'd0},
        '{FUNC_RD_PIX,  10'd0,    9'd0,   8'd0,   1'b1, 8'd2,   1'b0, CFG_PIXEL_MODE, 10'd0}
    };

    // ---------------- predictor ----------------
    function automatic int width_used();
        return (cur_width > MAX_W) ? MAX_W : int'(cur_width);
    endfunction

    function automatic int height_used();
        return (cur_height > MAX_H) ? MAX_H : int'(cur_height);
    endfunction

    function automatic bit pix_get(int x, int y);
        if (x >= width_used() || y >= height_used())
            return 1'b0;
        return pixel_mem[y*MAX_W + x];
    endfunction

    function automatic void pix_put(int x, int y, bit b);
        if (x < width_used() && y < height_used())
            pixel_mem[y*MAX_W + x] = b;
    endfunction

    function automatic bit cell_in_range(int cx, int cy);
        return cx < (width_used() + 7) / 8 && cy < (height_used() + 7) / 8;
    endfunction

    function automatic logic [7:0] cell_get(int cx, int cy);
        if (!cell_in_range(cx, cy))
            return 8'd0;
        return cell_mem[cy*CELL_COLS + cx];
    endfunction

    function automatic bit pixel_is_multi(int x, int y);
        return cur_mode == MODE_MULTI ||
               (cur_mode == MODE_CMAP && cell_get(x / 8, y / 8) > CELL_MC_LIMIT);
    endfunction

    // Applies one access to the shadow state and returns the rvalue it yields
    function automatic logic [7:0] access_result(func_t f, int x, int y, logic [7:0] v);
        int         xe;
        logic [7:0] wv;
        logic [7:0] r;
        xe = x & ~1;
        wv = v;
        r  = 8'd0;
        case (f)
            FUNC_RD_PIX:
            begin
                if (pixel_is_multi(x, y))
                    r = {6'd0, pix_get(xe, y), pix_get(xe + 1, y)};
                else
                    r = {7'd0, pix_get(x, y)};
            end
            FUNC_WR_PIX:
            begin
                if (pixel_is_multi(x, y))
                begin
                    if (cur_mode == MODE_CMAP && wv[0])
                        wv[1] = ~wv[1];
                    pix_put(xe, y, wv[1]);
                    pix_put(xe + 1, y, wv[0]);
                end
                else
                begin
                    pix_put(x, y, wv[0]);
                end
                r = wv;
            end
            FUNC_RD_CELL:
                r = cell_get(x, y);
            default:
            begin
                if (cell_in_range(x, y))
                    cell_mem[y*CELL_COLS + x] = v;
                r = v;
            end
        endcase
        return r;
    endfunction

    // ---------------- drivers ----------------
    // One access transfer; start stays high afterwards until hold_off lowers it
    task automatic send_access(input func_t f, input logic [9:0] x, input logic [8:0] y,
                               input logic [7:0] v, input logic chk, input logic [7:0] typed);
        logic [7:0] pred;
        @(negedge clk);
        start  = 1'b1;
        func   = f;
        xpos   = x;
        ypos   = y;
        wvalue = v;
        do
            @(posedge clk);
        while (busy);
        pred = access_result(f, x, y, v);
        rvalue_due.push_back(chk ? typed : pred);
        n_by_func[f]++;
    endtask

    task automatic hold_off(input int n);
        @(negedge clk);
        start = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Sender pause until every expected result is back, plus the block latency
    task automatic wait_drained();
        hold_off(1);
        while (rvalue_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_PIXEL_MODE:    cur_mode   = data[1:0];
            CFG_BITMAP_WIDTH:  cur_width  = data;
            CFG_BITMAP_HEIGHT: cur_height = data[8:0];
            default:           ;
        endcase
        n_reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // ---------------- result checker ----------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            n_results++;
            if (rvalue_due.size() == 0)
            begin
                $display("%0t ns: result with nothing expected, rvalue=%02h", $time, rvalue);
                errors++;
            end
            else
            begin
                want = rvalue_due.pop_front();
                if (rvalue !== want)
                begin
                    $display("%0t ns: rvalue mismatch, expected %02h, actual %02h",
                             $time, want, rvalue);
                    errors++;
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    initial
    begin
        func_t      f;
        logic [9:0] x;
        logic [9:0] xb;
        logic [8:0] y;
        logic [8:0] yb;
        logic [7:0] v;
        logic [1:0] md;
        logic [9:0] wd;
        logic [8:0] hd;
        int         w;
        int         h;
        int         r;
        int         n;
        bit         quiet;

        start     = 1'b0;
        func      = FUNC_RD_PIX;
        xpos      = '0;
        ypos      = '0;
        wvalue    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PIXEL_MODE;
        cfg_data  = '0;
        rst_n     = 1'b0;
        xb        = '0;
        yb        = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (int i = 0; i < DIR_N; i++)
        begin
            if (dir_rows[i].is_reg)
            begin
                wait_drained();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end
            else
            begin
                send_access(dir_rows[i].f, dir_rows[i].x, dir_rows[i].y, dir_rows[i].v,
                            dir_rows[i].chk, dir_rows[i].typed);
            end
        end

        // random phases, each under its own size and mode
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0:       begin md = MODE_CMAP;  wd = 10'd320;  hd = 9'd192; end
                1:       begin md = MODE_MULTI; wd = 10'd1023; hd = 9'd511; end
                2:       begin md = MODE_HIRES; wd = 10'd0;    hd = 9'd256; end
                3:       begin md = MODE_THREE; wd = 10'd512;  hd = 9'd0;   end
                4:       begin md = MODE_CMAP;  wd = 10'd17;   hd = 9'd9;   end
                5:       begin md = MODE_CMAP;  wd = 10'd8;    hd = 9'd8;   end
                6:       begin md = MODE_MULTI; wd = 10'd319;  hd = 9'd255; end
                default:
                begin
                    md = 2'($urandom_range(0, 3));
                    if ($urandom_range(0, 1) == 0)
                        md = MODE_CMAP;
                    wd = 10'($urandom_range(8, 520));
                    hd = 9'($urandom_range(8, 300));
                end
            endcase
            if (phase % 2 == 1)
                write_reg(CFG_BITMAP_HEIGHT, {1'b0, hd});
            write_reg(CFG_BITMAP_WIDTH, wd);
            if (phase % 2 == 0)
                write_reg(CFG_BITMAP_HEIGHT, {1'b0, hd});
            write_reg(CFG_PIXEL_MODE, {8'd0, md});
            w = width_used();
            h = height_used();
            quiet = (phase % 4 == 2);

            for (int k = 0; k < PHASE_LEN; k++)
            begin
                // working window: origin, bottom-right edge or anywhere inside
                if (k == 0 || $urandom_range(0, 19) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       begin xb = '0; yb = '0; end
                        1:
                        begin
                            xb = (w > 12) ? 10'(w - 12) : '0;
                            yb = (h > 6) ? 9'(h - 6) : '0;
                        end
                        default:
                        begin
                            xb = 10'($urandom_range(0, w));
                            yb = 9'($urandom_range(0, h));
                        end
                    endcase
                end

                r = $urandom_range(0, 99);
                if (r < 38)
                    f = FUNC_RD_PIX;
                else if (r < 76)
                    f = FUNC_WR_PIX;
                else if (r < 88)
                    f = FUNC_WR_CELL;
                else
                    f = FUNC_RD_CELL;

                if ($urandom_range(0, 99) < 15)
                begin
                    x = 10'($urandom_range(0, 1023));
                    y = 9'($urandom_range(0, 511));
                end
                else if (f == FUNC_RD_PIX || f == FUNC_WR_PIX)
                begin
                    x = xb + 10'($urandom_range(0, 23));
                    y = yb + 9'($urandom_range(0, 11));
                end
                else if ($urandom_range(0, 1) == 0)
                begin
                    x = xb / 8 + 10'($urandom_range(0, 3));
                    y = yb / 8 + 9'($urandom_range(0, 2));
                end
                else
                begin
                    x = 10'($urandom_range(0, (w + 7) / 8 + 1));
                    y = 9'($urandom_range(0, (h + 7) / 8 + 1));
                end

                // cell bytes cluster around the multicolor threshold
                if (f == FUNC_WR_CELL && $urandom_range(0, 1) == 0)
                    v = 8'($urandom_range(6, 9));
                else
                    v = 8'($urandom_range(0, 255));

                send_access(f, x, y, v, 1'b0, 8'd0);

                if (!quiet)
                begin
                    r = $urandom_range(0, 99);
                    if (r >= 92)
                        hold_off($urandom_range(8, 40));
                    else if (r >= 60)
                        hold_off($urandom_range(1, 3));
                end
                if ($urandom_range(0, 199) == 0 || (phase == 3 && k == PHASE_LEN / 2))
                    wait_drained();
            end
        end

        // final drain, bounded
        hold_off(1);
        n = 0;
        while (rvalue_due.size() != 0 && n < 200)
        begin
            @(posedge clk);
            n++;
        end
        if (rvalue_due.size() != 0)
        begin
            $display("%0t ns: %0d expected results never arrived", $time, rvalue_due.size());
            errors++;
        end
        repeat (8) @(posedge clk);

        $display("Ran %0d pixel reads, %0d pixel writes, %0d cell reads, %0d cell writes",
                 n_by_func[FUNC_RD_PIX], n_by_func[FUNC_WR_PIX],
                 n_by_func[FUNC_RD_CELL], n_by_func[FUNC_WR_CELL]);
        $display("over %0d register writes in all four modes; %0d results compared, %0d errors",
                 n_reg_writes, n_results, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("%0t ns: timeout", $time);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
